// ----- rtl/gdpl_pkg.sv -----
`default_nettype none

package gdpl_pkg;

	// Default parameter values for the top level.
	localparam int POSITION_BITS_DEF = 32;
	localparam int INDEX_BITS_DEF    = 12;

	// Fixed widths of the configuration registers.
	localparam int PITCH_BITS  = 24;
	localparam int COUNT_BITS  = 13;
	localparam int GAP_BITS    = 30;
	localparam int EDGE_BITS   = GAP_BITS + 1;
	localparam int PERIOD_BITS = GAP_BITS + 2;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = GAP_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_X_PITCH     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_Y_PITCH     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_X_COUNT     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_Y_COUNT     = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNIT_LENGTH = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNIT_GAP    = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ARRAY_GAP   = 3'd6;

	// Register values after reset.
	localparam logic [PITCH_BITS-1:0] PITCH_RESET = 24'd75000;
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = 13'd64;

	// Gap geometry derived from the configuration, shared by both lanes.
	typedef struct packed {
		logic                   gapped;
		logic [GAP_BITS-1:0]    unit_length;
		logic [EDGE_BITS-1:0]   lo_edge;
		logic [PERIOD_BITS-1:0] span;
		logic [PERIOD_BITS-1:0] period;
	} geom_t;

	// Pipeline flow control toward the data path.
	typedef struct packed {
		logic en;
		logic load_out;
		logic out_from_skid;
		logic load_skid;
	} flow_t;

endpackage

`default_nettype wire

// ----- rtl/gapped_detector_pixel_locate_unit.sv -----
`default_nettype none

// Maps an impact position (pos_x, pos_y), signed nanometres from the detector
// corner, to a pixel column and row with a hit flag; a hit in a gap, at a negative
// position or beyond the pixel counts returns flag 0 and both indices 0. Each axis
// runs in its own lane with two restoring dividers, one quotient bit per stage:
// one divides by the pitch, the other folds the position by the array period. The
// block takes one item per cycle while the skid slot is empty; an accepted item
// passes the input register, which loads at the accepting edge itself, then the
// POSITION_BITS-1 divider stages and the output register.
// A skid slot lets one more item in while a result waits.
// Configuration writes are always taken and must be made while no item is in flight.
module gapped_detector_pixel_locate_unit #(
	parameter int POSITION_BITS = gdpl_pkg::POSITION_BITS_DEF,
	parameter int INDEX_BITS    = gdpl_pkg::INDEX_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// Fields from bit 0 up: pos_x, pos_y, zero fill.
	input  wire logic [((2*POSITION_BITS+7)/8)*8-1:0]  s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// Fields from bit 0 up: pixel_x, pixel_y, zero fill.
	output logic      [((2*INDEX_BITS+7)/8)*8-1:0]     m_axis_tdata,
	// Fields from bit 0 up: hit_valid.
	output logic                                       m_axis_tuser,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [gdpl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [gdpl_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	import gdpl_pkg::*;

	localparam int OUT_W = ((2*INDEX_BITS+7)/8)*8;
	localparam int DEPTH = POSITION_BITS;

	logic [PITCH_BITS-1:0] x_pitch_q;
	logic [PITCH_BITS-1:0] y_pitch_q;
	logic [COUNT_BITS-1:0] x_count_q;
	logic [COUNT_BITS-1:0] y_count_q;
	logic [GAP_BITS-1:0]   unit_length_q;
	logic [GAP_BITS-1:0]   unit_gap_q;
	logic [GAP_BITS-1:0]   array_gap_q;
	geom_t                 geom_q;
	flow_t                 ctrl;

	logic                  ok_x;
	logic                  ok_y;
	logic [INDEX_BITS-1:0] idx_x;
	logic [INDEX_BITS-1:0] idx_y;
	logic                  hit;
	logic [INDEX_BITS-1:0] res_x;
	logic [INDEX_BITS-1:0] res_y;
	logic [INDEX_BITS-1:0] skid_x_q;
	logic [INDEX_BITS-1:0] skid_y_q;
	logic                  skid_hit_q;
	logic [INDEX_BITS-1:0] pixel_x_q;
	logic [INDEX_BITS-1:0] pixel_y_q;
	logic                  hit_valid_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_pitch_q     <= PITCH_RESET;
			y_pitch_q     <= PITCH_RESET;
			x_count_q     <= COUNT_RESET;
			y_count_q     <= COUNT_RESET;
			unit_length_q <= '0;
			unit_gap_q    <= '0;
			array_gap_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_X_PITCH:     x_pitch_q     <= cfg_data[PITCH_BITS-1:0];
				REG_Y_PITCH:     y_pitch_q     <= cfg_data[PITCH_BITS-1:0];
				REG_X_COUNT:     x_count_q     <= cfg_data[COUNT_BITS-1:0];
				REG_Y_COUNT:     y_count_q     <= cfg_data[COUNT_BITS-1:0];
				REG_UNIT_LENGTH: unit_length_q <= cfg_data[GAP_BITS-1:0];
				REG_UNIT_GAP:    unit_gap_q    <= cfg_data[GAP_BITS-1:0];
				REG_ARRAY_GAP:   array_gap_q   <= cfg_data[GAP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Gap geometry: second unit edges and the array period.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q <= '0;
		end else begin
			geom_q.gapped      <= unit_length_q != '0;
			geom_q.unit_length <= unit_length_q;
			geom_q.lo_edge     <= EDGE_BITS'(unit_length_q) + EDGE_BITS'(unit_gap_q);
			geom_q.span        <= {1'b0, unit_length_q, 1'b0} + PERIOD_BITS'(unit_gap_q);
			geom_q.period      <= {1'b0, unit_length_q, 1'b0} + PERIOD_BITS'(unit_gap_q)
				+ PERIOD_BITS'(array_gap_q);
		end
	end

	gdpl_flow_ctrl #(
		.DEPTH (DEPTH)
	) u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctrl      (ctrl)
	);

	gdpl_axis_lane #(
		.POS_BITS (POSITION_BITS),
		.IDX_BITS (INDEX_BITS)
	) u_lane_x (
		.clk   (clk),
		.en    (ctrl.en),
		.pos   (s_axis_tdata[POSITION_BITS-1:0]),
		.pitch (x_pitch_q),
		.count (x_count_q),
		.geom  (geom_q),
		.ok    (ok_x),
		.idx   (idx_x)
	);

	gdpl_axis_lane #(
		.POS_BITS (POSITION_BITS),
		.IDX_BITS (INDEX_BITS)
	) u_lane_y (
		.clk   (clk),
		.en    (ctrl.en),
		.pos   (s_axis_tdata[2*POSITION_BITS-1:POSITION_BITS]),
		.pitch (y_pitch_q),
		.count (y_count_q),
		.geom  (geom_q),
		.ok    (ok_y),
		.idx   (idx_y)
	);

	// Merge: a hit needs both axes; a miss zeroes both indices.
	assign hit   = ok_x && ok_y;
	assign res_x = hit ? idx_x : '0;
	assign res_y = hit ? idx_y : '0;

	// Skid slot and output register.
	always_ff @(posedge clk) begin
		if (ctrl.load_skid) begin
			skid_x_q   <= res_x;
			skid_y_q   <= res_y;
			skid_hit_q <= hit;
		end
		if (ctrl.load_out) begin
			if (ctrl.out_from_skid) begin
				pixel_x_q   <= skid_x_q;
				pixel_y_q   <= skid_y_q;
				hit_valid_q <= skid_hit_q;
			end else begin
				pixel_x_q   <= res_x;
				pixel_y_q   <= res_y;
				hit_valid_q <= hit;
			end
		end
	end

	assign m_axis_tdata = OUT_W'({pixel_y_q, pixel_x_q});
	assign m_axis_tuser = hit_valid_q;

endmodule

`default_nettype wire

// ----- rtl/gdpl_div_pipe.sv -----
`default_nettype none

// Restoring divider, one quotient bit per pipeline stage.
module gdpl_div_pipe #(
	parameter int N = 31,
	parameter int M = 24
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [N-1:0] dividend,
	input  wire logic [M-1:0] divisor,
	output logic      [N-1:0] quotient,
	output logic      [M-1:0] remainder
);

	logic [M-1:0] rem_s [N];
	logic [N-1:0] quo_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [M-1:0] rem_in;
		logic [N-1:0] quo_in;
		logic [M:0]   trial;
		logic [M:0]   diff;
		logic         take;

		// The dividend shifts out at the top while quotient bits shift in.
		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = dividend;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = {rem_in, quo_in[N-1]};
		assign diff  = trial - {1'b0, divisor};
		assign take  = trial >= {1'b0, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? diff[M-1:0] : trial[M-1:0];
				quo_s[k] <= {quo_in[N-2:0], take};
			end
		end
	end

	assign quotient  = quo_s[N-1];
	assign remainder = rem_s[N-1];

endmodule

`default_nettype wire

// ----- rtl/gdpl_axis_lane.sv -----
`default_nettype none

// One axis: pixel index by pitch division, gap test by period remainder.
module gdpl_axis_lane #(
	parameter int POS_BITS = 32,
	parameter int IDX_BITS = 12
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic        [POS_BITS-1:0]     pos,
	input  wire logic [gdpl_pkg::PITCH_BITS-1:0] pitch,
	input  wire logic [gdpl_pkg::COUNT_BITS-1:0] count,
	input  wire gdpl_pkg::geom_t                geom,
	output logic                                ok,
	output logic             [IDX_BITS-1:0]     idx
);

	import gdpl_pkg::*;

	localparam int MAG = POS_BITS - 1;
	localparam int QW  = (MAG > IDX_BITS) ? MAG : IDX_BITS;
	localparam int CW  = (QW > COUNT_BITS) ? QW : COUNT_BITS;

	logic [MAG-1:0]         mag_s0;
	logic                   neg_s0;
	logic                   neg_s [MAG];
	logic [MAG-1:0]         quo;
	logic [MAG-1:0]         unused_quo;
	logic [PITCH_BITS-1:0]  unused_rem;
	logic [PERIOD_BITS-1:0] rem;
	logic [QW-1:0]          q_ext;
	logic                   on_first;
	logic                   on_second;
	logic                   on_silicon;
	logic                   fits;
	logic                   in_count;

	// Input register: sign and magnitude of the position.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s0 <= pos[MAG-1:0];
			neg_s0 <= pos[POS_BITS-1];
		end
	end

	// The sign travels alongside the divider stages.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= neg_s0;
			for (int k = 1; k < MAG; k++) begin
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	gdpl_div_pipe #(
		.N (MAG),
		.M (PITCH_BITS)
	) u_pitch_div (
		.clk       (clk),
		.en        (en),
		.dividend  (mag_s0),
		.divisor   (pitch),
		.quotient  (quo),
		.remainder (unused_rem)
	);

	gdpl_div_pipe #(
		.N (MAG),
		.M (PERIOD_BITS)
	) u_period_div (
		.clk       (clk),
		.en        (en),
		.dividend  (mag_s0),
		.divisor   (geom.period),
		.quotient  (unused_quo),
		.remainder (rem)
	);

	// Gap test on the folded position; boundaries count as gap, but a remainder of zero is on the first unit.
	assign on_first   = rem < PERIOD_BITS'(geom.unit_length);
	assign on_second  = (rem > PERIOD_BITS'(geom.lo_edge)) && (rem < geom.span);
	assign on_silicon = !geom.gapped || on_first || on_second;

	// Range checks on the pixel index.
	assign q_ext    = QW'(quo);
	assign fits     = (q_ext >> IDX_BITS) == '0;
	assign in_count = CW'(q_ext) < CW'(count);

	assign ok  = !neg_s[MAG-1] && (pitch != '0) && on_silicon && fits && in_count;
	assign idx = q_ext[IDX_BITS-1:0];

endmodule

`default_nettype wire

// ----- rtl/gdpl_flow_ctrl.sv -----
`default_nettype none

// Valid tracking for the lane pipeline, with a skid slot before the output register.
module gdpl_flow_ctrl #(
	parameter int DEPTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output gdpl_pkg::flow_t      ctrl
);

	import gdpl_pkg::*;

	logic [DEPTH-1:0] valid_q;
	logic             skid_q;
	logic             out_q;
	logic             out_free;
	logic             pipe_valid;

	assign pipe_valid = valid_q[DEPTH-1];
	assign out_free   = !out_q || out_ready;

	// The pipeline moves as long as the skid slot is empty.
	always_comb begin
		ctrl.en            = !skid_q;
		ctrl.load_out      = out_free;
		ctrl.out_from_skid = skid_q;
		ctrl.load_skid     = !out_free && !skid_q && pipe_valid;
	end

	assign in_ready  = !skid_q;
	assign out_valid = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			skid_q  <= 1'b0;
			out_q   <= 1'b0;
		end else begin
			if (!skid_q) begin
				valid_q <= {valid_q[DEPTH-2:0], in_valid};
			end
			if (out_free) begin
				out_q  <= skid_q || pipe_valid;
				skid_q <= 1'b0;
			end else if (!skid_q && pipe_valid) begin
				skid_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/gdpl_checker.sv -----
`default_nettype none

// Port-level checks for the pixel locate unit.
module gdpl_checker #(
	parameter int POSITION_BITS = gdpl_pkg::POSITION_BITS_DEF,
	parameter int INDEX_BITS    = gdpl_pkg::INDEX_BITS_DEF
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_axis_tvalid,
	input wire logic                              s_axis_tready,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	// Fields from bit 0 up: pixel_x, pixel_y, zero fill.
	input wire logic [((2*INDEX_BITS+7)/8)*8-1:0] m_axis_tdata,
	// Fields from bit 0 up: hit_valid.
	input wire logic                              m_axis_tuser
);

	// Pipeline stages plus the skid slot and the output register.
	localparam int CAPACITY = POSITION_BITS + 2;
	localparam int CNT_W    = $clog2(CAPACITY + 2) + 1;

	logic [CNT_W-1:0] pending_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Items accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("missed hit carries nonzero indices");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != '0)
		else $error("result without an accepted item");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready))
		else $error("input stalled while the output was free");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(CAPACITY))
		else $error("more items in flight than storage");

endmodule

bind gapped_detector_pixel_locate_unit gdpl_checker #(
	.POSITION_BITS (POSITION_BITS),
	.INDEX_BITS    (INDEX_BITS)
) u_gdpl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/sv/pixel_locate_monitor.sv -----
// Watches the position, pixel and configuration channels of the pixel locator.
// It keeps its own copy of the geometry registers, works out the pixel hit for
// every accepted position item and compares each accepted pixel item with the
// oldest hit still waiting.
module pixel_locate_monitor #(
	parameter int POSITION_BITS = 32,
	parameter int INDEX_BITS    = 12
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	input  logic                                      s_axis_tready,
	input  logic [((2*POSITION_BITS+7)/8)*8-1:0]      s_axis_tdata,
	input  logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	input  logic [((2*INDEX_BITS+7)/8)*8-1:0]         m_axis_tdata,
	input  logic                                      m_axis_tuser,
	input  logic                                      cfg_valid,
	input  logic                                      cfg_ready,
	input  logic [gdpl_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [gdpl_pkg::CFG_DATA_BITS-1:0]        cfg_data,
	output int                                        errors,
	output int                                        results_seen,
	output int                                        hits_waiting
);

	import gdpl_pkg::*;

	typedef struct packed {
		logic [INDEX_BITS-1:0] px;
		logic [INDEX_BITS-1:0] py;
		logic                  hit;
	} pixel_hit_t;

	// Geometry as the block should hold it.
	logic [PITCH_BITS-1:0] pitch_x, pitch_y;
	logic [COUNT_BITS-1:0] cols, rows;
	logic [GAP_BITS-1:0]   unit_len, unit_gap_len, array_gap_len;

	pixel_hit_t expected_hits[$];

	// One axis: sign check, gap folding by the array period, then the pixel index.
	function automatic logic locate_axis(input logic [POSITION_BITS-1:0] pos,
			input logic [PITCH_BITS-1:0] pitch, input logic [COUNT_BITS-1:0] count,
			output logic [INDEX_BITS-1:0] idx);
		longint unsigned p, span, period, r, q;
		p = pos;
		idx = '0;
		if (pos[POSITION_BITS-1])
			return 1'b0;
		if (pitch == 0)
			return 1'b0;
		if (unit_len != 0) begin
			span = 2 * 64'(unit_len) + 64'(unit_gap_len);
			period = span + 64'(array_gap_len);
			r = p % period;
			if (!(r < unit_len || (r > 64'(unit_len) + 64'(unit_gap_len) && r < span)))
				return 1'b0;
		end
		q = p / pitch;
		if (q >= count || q >= (64'd1 << INDEX_BITS))
			return 1'b0;
		idx = q[INDEX_BITS-1:0];
		return 1'b1;
	endfunction

	// Both axes must land on a pixel; otherwise the item carries zero indices.
	function automatic pixel_hit_t locate_pixel(input logic [((2*POSITION_BITS+7)/8)*8-1:0] d);
		pixel_hit_t h;
		logic [INDEX_BITS-1:0] ix, iy;
		logic vx, vy;
		vx = locate_axis(d[POSITION_BITS-1:0], pitch_x, cols, ix);
		vy = locate_axis(d[2*POSITION_BITS-1:POSITION_BITS], pitch_y, rows, iy);
		h.hit = vx && vy;
		h.px = h.hit ? ix : '0;
		h.py = h.hit ? iy : '0;
		return h;
	endfunction

	// Register writes, predictions and comparisons, all sampled at the clock edge.
	always @(posedge clk or negedge arst_n) begin
		pixel_hit_t got, want;
		if (!arst_n) begin
			pitch_x = PITCH_RESET;
			pitch_y = PITCH_RESET;
			cols = COUNT_RESET;
			rows = COUNT_RESET;
			unit_len = '0;
			unit_gap_len = '0;
			array_gap_len = '0;
			expected_hits.delete();
			errors = 0;
			results_seen = 0;
			hits_waiting = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_X_PITCH: pitch_x = cfg_data[PITCH_BITS-1:0];
					REG_Y_PITCH: pitch_y = cfg_data[PITCH_BITS-1:0];
					REG_X_COUNT: cols = cfg_data[COUNT_BITS-1:0];
					REG_Y_COUNT: rows = cfg_data[COUNT_BITS-1:0];
					REG_UNIT_LENGTH: unit_len = cfg_data[GAP_BITS-1:0];
					REG_UNIT_GAP: unit_gap_len = cfg_data[GAP_BITS-1:0];
					REG_ARRAY_GAP: array_gap_len = cfg_data[GAP_BITS-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_hits.push_back(locate_pixel(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.px = m_axis_tdata[INDEX_BITS-1:0];
				got.py = m_axis_tdata[2*INDEX_BITS-1:INDEX_BITS];
				got.hit = m_axis_tuser;
				results_seen++;
				if (expected_hits.size() == 0) begin
					$display("%0t: pixel item with none expected: x %0d y %0d hit %0d",
						$time, got.px, got.py, got.hit);
					errors++;
				end else begin
					want = expected_hits.pop_front();
					if (got.px !== want.px) begin
						$display("%0t: pixel_x expected %0d, got %0d", $time, want.px, got.px);
						errors++;
					end
					if (got.py !== want.py) begin
						$display("%0t: pixel_y expected %0d, got %0d", $time, want.py, got.py);
						errors++;
					end
					if (got.hit !== want.hit) begin
						$display("%0t: hit_valid expected %0d, got %0d", $time, want.hit, got.hit);
						errors++;
					end
				end
			end
			hits_waiting = expected_hits.size();
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
module tb;

	import gdpl_pkg::*;

	localparam int POS_BITS     = POSITION_BITS_DEF;
	localparam int IDX_BITS     = INDEX_BITS_DEF;
	localparam int IN_W         = ((2*POS_BITS+7)/8)*8;
	localparam int OUT_W        = ((2*IDX_BITS+7)/8)*8;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = POS_BITS + 16;
	localparam int RANDOM_SETS  = 7;
	localparam int SET_ITEMS    = 107;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_W-1:0]           s_axis_tdata = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_W-1:0]          m_axis_tdata;
	logic                      m_axis_tuser;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	int errors, results_seen, hits_waiting;

	// Positions waiting to be sent, and the geometry currently loaded.
	logic [IN_W-1:0] position_queue[$];
	int              positions_sent = 0;
	bit              quiet = 1'b0;
	longint          cur_pitch_x = 75000, cur_pitch_y = 75000;
	longint          cur_cols = 64, cur_rows = 64;
	longint          cur_unit = 0, cur_unit_gap = 0, cur_array_gap = 0;

	int src_gap = 0;
	int sink_stall = 0;
	int idle_cycles = 0;

	gapped_detector_pixel_locate_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pixel_locate_monitor #(.POSITION_BITS(POS_BITS), .INDEX_BITS(IDX_BITS)) locate_mon (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .results_seen(results_seen), .hits_waiting(hits_waiting)
	);

	always #4 clk = ~clk;

	// Mostly no gap, sometimes a few cycles, rarely a long pause.
	function automatic int pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 88)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Position source: one assignment to tvalid per edge, gaps between items.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (position_queue.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= position_queue.pop_front();
				src_gap = quiet ? 0 : pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Pixel sink with random stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (sink_stall > 0) begin
			sink_stall--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			sink_stall = quiet ? 0 : pick_gap();
		end
	end

	// Watchdog on cycles in which no channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Leaves cfg_valid high so back-to-back writes need no second assignment.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input longint value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_BITS-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_geometry(input longint px, input longint py, input longint cx,
			input longint cy, input longint ul, input longint ug, input longint ag);
		write_reg(REG_X_PITCH, px);
		write_reg(REG_Y_PITCH, py);
		write_reg(REG_X_COUNT, cx);
		write_reg(REG_Y_COUNT, cy);
		write_reg(REG_UNIT_LENGTH, ul);
		write_reg(REG_UNIT_GAP, ug);
		write_reg(REG_ARRAY_GAP, ag);
		cfg_valid <= 1'b0;
		cur_pitch_x = px;
		cur_pitch_y = py;
		cur_cols = cx;
		cur_rows = cy;
		cur_unit = ul;
		cur_unit_gap = ug;
		cur_array_gap = ag;
	endtask

	task automatic push_pos(input logic [POS_BITS-1:0] x, input logic [POS_BITS-1:0] y);
		logic [IN_W-1:0] d;
		d = '0;
		d[POS_BITS-1:0] = x;
		d[2*POS_BITS-1:POS_BITS] = y;
		position_queue.push_back(d);
		positions_sent++;
	endtask

	// Waits until every sent position has come back as a pixel item.
	task automatic wait_drained();
		do @(posedge clk); while (results_seen < positions_sent);
	endtask

	task automatic random_geometry();
		longint px, py, cx, cy, ul, ug, ag;
		px = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24'hFFFFFF) : $urandom_range(1, 3000);
		py = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24'hFFFFFF) : $urandom_range(1, 3000);
		cx = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 4096 : 1) : $urandom_range(1, 4096);
		cy = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 4096 : 1) : $urandom_range(1, 4096);
		if ($urandom_range(0, 3) == 0)
			ul = 0;
		else if ($urandom_range(0, 7) == 0)
			ul = $urandom_range(1, 30'h3FFFFFFF);
		else
			ul = $urandom_range(1, 20000);
		ug = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 3000);
		ag = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 3000);
		if ($urandom_range(0, 7) == 0)
			ug = $urandom_range(0, 30'h3FFFFFFF);
		if ($urandom_range(0, 7) == 0)
			ag = $urandom_range(0, 30'h3FFFFFFF);
		set_geometry(px, py, cx, cy, ul, ug, ag);
	endtask

	// Mostly positions on the pixel array, many near gap or pixel boundaries,
	// some negative, beyond the array, or fully random.
	function automatic logic [POS_BITS-1:0] random_pos(input longint pitch, input longint count);
		longint extent, span, period, boundary, v;
		int unsigned roll;
		extent = pitch * count;
		if (extent < 1)
			extent = 1;
		if (extent > (longint'(1) << (POS_BITS - 1)))
			extent = longint'(1) << (POS_BITS - 1);
		roll = $urandom_range(0, 9);
		if (roll < 5) begin
			v = $urandom_range(0, extent - 1);
		end else if (roll < 7) begin
			if (cur_unit != 0) begin
				span = 2 * cur_unit + cur_unit_gap;
				period = span + cur_array_gap;
				case ($urandom_range(0, 3))
					0: boundary = 0;
					1: boundary = cur_unit;
					2: boundary = cur_unit + cur_unit_gap;
					default: boundary = span;
				endcase
				v = period * $urandom_range(0, extent / period) + boundary;
			end else begin
				v = pitch * $urandom_range(0, count);
			end
			v = v + $urandom_range(0, 2);
			v = v - 1;
		end else if (roll == 7) begin
			v = $urandom | (longint'(1) << (POS_BITS - 1));
		end else if (roll == 8) begin
			v = extent + $urandom_range(0, 2 * pitch);
		end else begin
			v = $urandom;
		end
		return v[POS_BITS-1:0];
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset geometry: 75 um pitch, 64 x 64 pixels, no gaps.
		push_pos(0, 0);
		push_pos(4799999, 4799999);
		push_pos(4800000, 0);
		push_pos(32'hFFFF_FFFF, 0);
		push_pos(32'h8000_0000, 32'h7FFF_FFFF);
		wait_drained();

		// Unit pitch with the largest array: every index bit both ways.
		set_geometry(1, 1, 4096, 4096, 0, 0, 0);
		push_pos(4095, 4095);
		push_pos(4096, 0);
		push_pos(2730, 1365);
		wait_drained();

		// Largest pitch, one pixel; gap lengths are ignored while unit length is zero.
		set_geometry(24'hFFFFFF, 24'hFFFFFF, 1, 1, 0, 30'h3FFFFFFF, 30'h3FFFFFFF);
		push_pos(16777214, 16777214);
		push_pos(16777215, 0);
		wait_drained();

		// Gapped geometry with a 2400 nm period: hits on and just off each gap edge.
		set_geometry(50, 50, 4096, 4096, 1000, 100, 300);
		push_pos(0, 999);
		push_pos(1000, 0);
		push_pos(1100, 0);
		push_pos(1101, 2099);
		push_pos(2100, 0);
		push_pos(2399, 0);
		push_pos(3399, 3501);
		wait_drained();

		// A zero pitch makes every hit invalid.
		set_geometry(0, 75000, 64, 64, 0, 0, 0);
		push_pos(0, 0);
		push_pos(100, 100);
		wait_drained();

		// Largest unit and gap lengths; the top of the position range is on the second unit.
		set_geometry(24'hFFFFFF, 24'hFFFFFF, 4096, 4096,
			30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF);
		push_pos(32'h3FFF_FFFE, 0);
		push_pos(32'h3FFF_FFFF, 0);
		push_pos(32'h7FFF_FFFE, 0);
		push_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		wait_drained();

		// Random geometries, each with a batch of random positions.
		for (int set = 0; set < RANDOM_SETS; set++) begin
			quiet = (set % 3 == 1);
			random_geometry();
			repeat (SET_ITEMS)
				push_pos(random_pos(cur_pitch_x, cur_cols), random_pos(cur_pitch_y, cur_rows));
			wait_drained();
		end
		quiet = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && hits_waiting == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
